### design/cta_pkg.sv
// Shared types, constants, microcode table and calendar helpers for the calendar time adder.
`default_nettype none

package cta_pkg;

    localparam int N_W       = 17;  // dividend / quotient width of the divider
    localparam int R_W       = 9;   // remainder / divisor width (largest divisor is 400)
    localparam int CNT_W     = 2;   // divider step counter
    localparam int YEAR_W    = 18;  // year kept wide until saturation
    localparam int DAY_W     = 17;  // day sum before month reduction
    localparam int PC_W      = 4;   // microprogram counter

    // reciprocal scaling: the estimate is at most one below the true quotient
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = 21;
    localparam int PROD_W      = N_W + RECIP_W;

    localparam logic [CNT_W-1:0] DIV_MUL  = CNT_W'(0);
    localparam logic [CNT_W-1:0] DIV_EST  = CNT_W'(1);
    localparam logic [CNT_W-1:0] DIV_PART = CNT_W'(2);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(3);

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    localparam logic [R_W-1:0] DIVISOR_60  = R_W'(60);
    localparam logic [R_W-1:0] DIVISOR_24  = R_W'(24);
    localparam logic [R_W-1:0] DIVISOR_12  = R_W'(12);
    localparam logic [R_W-1:0] DIVISOR_400 = R_W'(400);

    localparam logic [RECIP_W-1:0] RECIP_60  = RECIP_W'((2 ** RECIP_SHIFT) / 60);
    localparam logic [RECIP_W-1:0] RECIP_24  = RECIP_W'((2 ** RECIP_SHIFT) / 24);
    localparam logic [RECIP_W-1:0] RECIP_12  = RECIP_W'((2 ** RECIP_SHIFT) / 12);
    localparam logic [RECIP_W-1:0] RECIP_400 = RECIP_W'((2 ** RECIP_SHIFT) / 400);

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_APR = 4'd4;
    localparam logic [3:0] MONTH_JUN = 4'd6;
    localparam logic [3:0] MONTH_SEP = 4'd9;
    localparam logic [3:0] MONTH_NOV = 4'd11;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    localparam logic [4:0] LEN_31 = 5'd31;
    localparam logic [4:0] LEN_30 = 5'd30;
    localparam logic [4:0] LEN_29 = 5'd29;
    localparam logic [4:0] LEN_28 = 5'd28;

    localparam logic [R_W-1:0] YMOD_LAST = R_W'(399);

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LD_SEC,
        OP_DIV,
        OP_ST_SEC,
        OP_ST_MIN,
        OP_ST_HOUR,
        OP_ST_YMOD,
        OP_DAY_STEP,
        OP_LD_MON,
        OP_ST_MON,
        OP_ADD_YEAR,
        OP_EMIT,
        OP_EMIT_INV
    } t_op;

    typedef enum logic [1:0] {
        DSEL_60,
        DSEL_24,
        DSEL_12,
        DSEL_400
    } t_dsel;

    typedef enum logic [2:0] {
        J_NEXT,
        J_INVALID,
        J_DIV_BUSY,
        J_DAY_OVER,
        J_END
    } t_jcond;

    typedef struct packed {
        t_op              op;
        t_dsel            dsel;
        t_jcond           jcond;
        logic [PC_W-1:0]  target;
    } t_ctrl;

    typedef struct packed {
        logic invalid;
        logic div_last;
        logic day_over;
    } t_flags;

    localparam logic [PC_W-1:0] PC_INV = PC_W'(15);

    localparam t_ctrl CTRL_IDLE = '{op: OP_NOP, dsel: DSEL_60, jcond: J_NEXT, target: '0};

    function automatic t_ctrl ucode(input logic [PC_W-1:0] pc);
        t_ctrl w;
        begin
            w = CTRL_IDLE;
            case (pc)
                4'd0: w = '{OP_LD_SEC,   DSEL_60,  J_INVALID,  PC_INV};
                4'd1: w = '{OP_DIV,      DSEL_60,  J_DIV_BUSY, 4'd1};
                4'd2: w = '{OP_ST_SEC,   DSEL_60,  J_NEXT,     4'd0};
                4'd3: w = '{OP_DIV,      DSEL_60,  J_DIV_BUSY, 4'd3};
                4'd4: w = '{OP_ST_MIN,   DSEL_24,  J_NEXT,     4'd0};
                4'd5: w = '{OP_DIV,      DSEL_24,  J_DIV_BUSY, 4'd5};
                4'd6: w = '{OP_ST_HOUR,  DSEL_400, J_NEXT,     4'd0};
                4'd7: w = '{OP_DIV,      DSEL_400, J_DIV_BUSY, 4'd7};
                4'd8: w = '{OP_ST_YMOD,  DSEL_400, J_NEXT,     4'd0};
                4'd9: w = '{OP_DAY_STEP, DSEL_12,  J_DAY_OVER, 4'd9};
                4'd10: w = '{OP_LD_MON,  DSEL_12,  J_NEXT,     4'd0};
                4'd11: w = '{OP_DIV,     DSEL_12,  J_DIV_BUSY, 4'd11};
                4'd12: w = '{OP_ST_MON,  DSEL_12,  J_NEXT,     4'd0};
                4'd13: w = '{OP_ADD_YEAR, DSEL_12, J_NEXT,     4'd0};
                4'd14: w = '{OP_EMIT,    DSEL_12,  J_END,      4'd0};
                4'd15: w = '{OP_EMIT_INV, DSEL_12, J_END,      4'd0};
                default: w = CTRL_IDLE;
            endcase
            return w;
        end
    endfunction

    // Leap test from the year modulo 400.
    function automatic logic is_leap(input logic [R_W-1:0] ymod);
        begin
            return (ymod[1:0] == 2'b00 && !(ymod inside {R_W'(100), R_W'(200), R_W'(300)}))
                   || ymod == '0;
        end
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] month,
                                             input logic [R_W-1:0] ymod);
        logic [4:0] len;
        begin
            case (month)
                MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = LEN_30;
                MONTH_FEB: len = is_leap(ymod) ? LEN_29 : LEN_28;
                default:   len = LEN_31;
            endcase
            return len;
        end
    endfunction

endpackage

`default_nettype wire

### design/cta_divider.sv
// Divider by a small constant through reciprocal multiplication, four steps per division.
`default_nettype none

module cta_divider
    import cta_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire logic             i_step,
    input  wire logic [N_W-1:0]   i_dividend,
    input  wire logic [R_W-1:0]   i_divisor,
    output logic [N_W-1:0]        o_quot,
    output logic [R_W-1:0]        o_rem,
    output logic                  o_last
);

    logic [N_W-1:0]     r_n;
    logic [R_W-1:0]     r_div;
    logic [RECIP_W-1:0] r_recip;
    logic [PROD_W-1:0]  r_prod;
    logic [N_W-1:0]     r_q;
    logic [N_W-1:0]     r_part;
    logic [R_W-1:0]     r_rem;
    logic [CNT_W-1:0]   r_cnt;

    logic [RECIP_W-1:0] recip;
    logic [N_W+R_W-1:0] qd;
    logic               ge;

    always_comb begin
        case (i_divisor)
            DIVISOR_60:  recip = RECIP_60;
            DIVISOR_24:  recip = RECIP_24;
            DIVISOR_12:  recip = RECIP_12;
            DIVISOR_400: recip = RECIP_400;
            default:     recip = RECIP_60;
        endcase
    end

    assign qd = r_q * r_div;
    assign ge = r_part >= N_W'(r_div);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= '0;
        end else if (i_step) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_n     <= i_dividend;
            r_div   <= i_divisor;
            r_recip <= recip;
        end else if (i_step) begin
            case (r_cnt)
                DIV_MUL:  r_prod <= r_n * r_recip;
                DIV_EST:  r_q    <= N_W'(r_prod[PROD_W-1:RECIP_SHIFT]);
                DIV_PART: r_part <= r_n - qd[N_W-1:0];
                default: begin
                    // estimate may fall one short: lift it when the remainder reaches the divisor
                    if (ge) begin
                        r_q   <= r_q + N_W'(1);
                        r_rem <= R_W'(r_part - N_W'(r_div));
                    end else begin
                        r_rem <= R_W'(r_part);
                    end
                end
            endcase
        end
    end

    assign o_quot = r_q;
    assign o_rem  = r_rem;
    assign o_last = r_cnt == DIV_LAST;

endmodule

`default_nettype wire

### design/cta_sequencer.sv
// Microprogram sequencer: step counter, control ROM and conditional jumps.
`default_nettype none

module cta_sequencer
    import cta_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_go,
    input  wire t_flags i_flags,
    output t_ctrl       o_ctrl,
    output logic        o_busy
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state          r_state;
    logic [PC_W-1:0] r_pc;
    t_ctrl           word;
    logic            take;

    assign word = ucode(r_pc);

    always_comb begin
        case (word.jcond)
            J_INVALID:  take = i_flags.invalid;
            J_DIV_BUSY: take = !i_flags.div_last;
            J_DAY_OVER: take = i_flags.day_over;
            default:    take = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_pc <= '0;
                    if (i_go) begin
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (word.jcond == J_END) begin
                        r_state <= S_IDLE;
                        r_pc    <= '0;
                    end else if (take) begin
                        r_pc <= word.target;
                    end else begin
                        r_pc <= r_pc + PC_W'(1);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_pc    <= '0;
                end
            endcase
        end
    end

    assign o_ctrl = (r_state == S_RUN) ? word : CTRL_IDLE;
    assign o_busy = r_state == S_RUN;

endmodule

`default_nettype wire

### design/calendar_time_adder.sv
// Top level: calendar time adder datapath driven by a microcoded sequencer.
// Result: the strobe is registered from the emit step; an invalid month or year jumps
// from the first step straight to the invalid emit.
// Throughput: one item at a time; busy stays high while the item runs (five divisions of four
// steps, ten single steps, one month per cycle in the day loop); next start in strobe cycle.
// Reset: synchronous active-low i_rst_n returns the sequencer to idle and drops the strobe.
`default_nettype none

module calendar_time_adder
    import cta_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [15:0] i_cur_year,
    input  wire logic [7:0]  i_cur_month,
    input  wire logic [4:0]  i_cur_day,
    input  wire logic [4:0]  i_cur_hour,
    input  wire logic [5:0]  i_cur_minute,
    input  wire logic [5:0]  i_cur_second,
    input  wire logic [15:0] i_add_years,
    input  wire logic [15:0] i_add_months,
    input  wire logic [15:0] i_add_days,
    input  wire logic [15:0] i_add_hours,
    input  wire logic [15:0] i_add_minutes,
    input  wire logic [15:0] i_add_seconds,
    output logic             o_strobe,
    output logic [1:0]       o_status,
    output logic [15:0]      o_new_year,
    output logic [3:0]       o_new_month,
    output logic [4:0]       o_new_day,
    output logic [4:0]       o_new_hour,
    output logic [5:0]       o_new_minute,
    output logic [5:0]       o_new_second
);

    logic              accept;
    t_ctrl             ctrl;
    t_flags            flags;

    logic              div_load;
    logic              div_step;
    logic [N_W-1:0]    dividend;
    logic [R_W-1:0]    divisor;
    logic [N_W-1:0]    quot;
    logic [R_W-1:0]    rem;
    logic              div_last;

    logic [YEAR_W-1:0] r_year;
    logic [R_W-1:0]    r_ymod;
    logic [3:0]        r_month;
    logic [DAY_W-1:0]  r_day;
    logic [4:0]        r_hour;
    logic [5:0]        r_min;
    logic [5:0]        r_sec;
    logic              r_invalid;
    logic [15:0]       r_add_year;
    logic [15:0]       r_add_mon;
    logic [15:0]       r_add_day;
    logic [15:0]       r_add_hour;
    logic [15:0]       r_add_min;
    logic [15:0]       r_add_sec;

    logic              r_strobe;
    logic [1:0]        r_status;
    logic [15:0]       r_new_year;
    logic [3:0]        r_new_month;
    logic [4:0]        r_new_day;
    logic [4:0]        r_new_hour;
    logic [5:0]        r_new_min;
    logic [5:0]        r_new_sec;

    logic [4:0]        len;
    logic              day_over;

    assign accept   = start && !busy;
    assign len      = month_len(r_month, r_ymod);
    assign day_over = r_day > {12'b0, len};

    assign flags = '{invalid: r_invalid, div_last: div_last, day_over: day_over};

    cta_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (accept),
        .i_flags (flags),
        .o_ctrl  (ctrl),
        .o_busy  (busy)
    );

    cta_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (div_load),
        .i_step     (div_step),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_quot     (quot),
        .o_rem      (rem),
        .o_last     (div_last)
    );

    always_comb begin
        case (ctrl.dsel)
            DSEL_60:  divisor = DIVISOR_60;
            DSEL_24:  divisor = DIVISOR_24;
            DSEL_12:  divisor = DIVISOR_12;
            DSEL_400: divisor = DIVISOR_400;
            default:  divisor = DIVISOR_60;
        endcase
    end

    // The seconds and minutes stores load the next division with the carry just produced.
    always_comb begin
        div_load = 1'b0;
        div_step = 1'b0;
        dividend = '0;
        case (ctrl.op)
            OP_LD_SEC: begin
                div_load = 1'b1;
                dividend = {11'b0, r_sec} + {1'b0, r_add_sec};
            end
            OP_ST_SEC: begin
                div_load = 1'b1;
                dividend = {11'b0, r_min} + {1'b0, r_add_min} + quot;
            end
            OP_ST_MIN: begin
                div_load = 1'b1;
                dividend = {12'b0, r_hour} + {1'b0, r_add_hour} + quot;
            end
            OP_ST_HOUR: begin
                div_load = 1'b1;
                dividend = {1'b0, r_year[15:0]};
            end
            OP_LD_MON: begin
                div_load = 1'b1;
                dividend = {13'b0, r_month - 4'd1} + {1'b0, r_add_mon};
            end
            OP_DIV: begin
                div_step = 1'b1;
            end
            default: begin
                div_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_year     <= {2'b0, i_cur_year};
            r_month    <= i_cur_month[3:0];
            r_day      <= {12'b0, i_cur_day};
            r_hour     <= i_cur_hour;
            r_min      <= i_cur_minute;
            r_sec      <= i_cur_second;
            r_invalid  <= i_cur_year == 16'd0 || i_cur_month < 8'd1 || i_cur_month > 8'd12;
            r_add_year <= i_add_years;
            r_add_mon  <= i_add_months;
            r_add_day  <= i_add_days;
            r_add_hour <= i_add_hours;
            r_add_min  <= i_add_minutes;
            r_add_sec  <= i_add_seconds;
        end else begin
            case (ctrl.op)
                OP_ST_SEC: r_sec <= rem[5:0];
                OP_ST_MIN: r_min <= rem[5:0];
                OP_ST_HOUR: begin
                    r_hour <= rem[4:0];
                    r_day  <= r_day + {1'b0, r_add_day} + quot;
                end
                OP_ST_YMOD: r_ymod <= rem;
                OP_DAY_STEP: begin
                    // drop one month's length and advance the month; past December also year and leap phase
                    if (day_over) begin
                        r_day <= r_day - {12'b0, len};
                        if (r_month == MONTH_DEC) begin
                            r_month <= MONTH_JAN;
                            r_year  <= r_year + YEAR_W'(1);
                            r_ymod  <= (r_ymod == YMOD_LAST) ? '0 : r_ymod + R_W'(1);
                        end else begin
                            r_month <= r_month + 4'd1;
                        end
                    end
                end
                OP_ST_MON: begin
                    r_month <= rem[3:0] + 4'd1;
                    r_year  <= r_year + {1'b0, quot};
                end
                OP_ADD_YEAR: r_year <= r_year + {2'b0, r_add_year};
                OP_EMIT: begin
                    r_status    <= (r_year[17:16] != 2'b00) ? ST_OVERFLOW : ST_OK;
                    r_new_year  <= (r_year[17:16] != 2'b00) ? 16'hFFFF : r_year[15:0];
                    r_new_month <= r_month;
                    r_new_day   <= r_day[4:0];
                    r_new_hour  <= r_hour;
                    r_new_min   <= r_min;
                    r_new_sec   <= r_sec;
                end
                OP_EMIT_INV: begin
                    r_status    <= ST_INVALID;
                    r_new_year  <= '0;
                    r_new_month <= '0;
                    r_new_day   <= '0;
                    r_new_hour  <= '0;
                    r_new_min   <= '0;
                    r_new_sec   <= '0;
                end
                default: begin
                    r_sec <= r_sec;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= ctrl.op == OP_EMIT || ctrl.op == OP_EMIT_INV;
        end
    end

    assign o_strobe     = r_strobe;
    assign o_status     = r_status;
    assign o_new_year   = r_new_year;
    assign o_new_month  = r_new_month;
    assign o_new_day    = r_new_day;
    assign o_new_hour   = r_new_hour;
    assign o_new_minute = r_new_min;
    assign o_new_second = r_new_sec;

    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result transfer without a job in progress");

    a_start_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not start the sequencer");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_status == ST_OK || o_status == ST_INVALID || o_status == ST_OVERFLOW))
        else $error("undefined status code");

    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != ST_INVALID) |-> (o_new_month >= 4'd1 && o_new_month <= 4'd12))
        else $error("result month out of range");

endmodule

`default_nettype wire
